### design/client_registry_heartbeat_macros.svh
// assertion macros for the client registry design, used by crh_back
// needs clk and rst_n in scope where a macro is used
`ifndef CLIENT_REGISTRY_HEARTBEAT_MACROS_SVH
`define CLIENT_REGISTRY_HEARTBEAT_MACROS_SVH

// condition holds on every edge out of reset
`define CRH_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CRH_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CRH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/crh_pkg.sv
// types, codes and defaults of the client registry
// no dependencies
package crh_pkg;

  localparam int TABLE_SIZE_DEF = 32;
  localparam int KEY_BITS_DEF   = 64;
  localparam int MAX_RESULTS    = 32;
  localparam logic [5:0] CLIENT_LIMIT_RST = 6'd20;

  // input kind codes
  localparam logic [2:0] KIND_REGISTER   = 3'd0;
  localparam logic [2:0] KIND_PONG       = 3'd1;
  localparam logic [2:0] KIND_UNREGISTER = 3'd2;
  localparam logic [2:0] KIND_SWEEP      = 3'd3;
  localparam logic [2:0] KIND_DISPATCH   = 3'd4;

  typedef enum logic [2:0] {
    STAT_ACCEPTED   = 3'd0,
    STAT_FULL       = 3'd1,
    STAT_NAME_USED  = 3'd2,
    STAT_NO_CLIENT  = 3'd3,
    STAT_DISPATCHED = 3'd4,
    STAT_PING       = 3'd5,
    STAT_NONE       = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    OP_REG,
    OP_PONG,
    OP_UNREG,
    OP_SWEEP,
    OP_DISP
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_COMPACT,
    ST_PING
  } state_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t          op;
    logic [63:0]  key;
    logic [15:0]  id;
    logic         link;
  } cmd_t;

endpackage

### design/crh_if.sv
// channel interfaces of the client registry: input, result, configuration
// no dependencies
interface crh_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] name_key;
  logic [15:0] client_id;
  logic        link;
  modport source (output valid, kind, name_key, client_id, link, input ready);
  modport sink (input valid, kind, name_key, client_id, link, output ready);
endinterface

interface crh_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] out_id;
  logic        out_link;
  logic [31:0] job_number;
  logic        last;
  modport source (output valid, status, out_id, out_link, job_number, last, input ready);
  modport sink (input valid, status, out_id, out_link, job_number, last, output ready);
endinterface

interface crh_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] client_limit;
  modport source (output valid, client_limit, input ready);
  modport sink (input valid, client_limit, output ready);
endinterface

### design/client_registry_heartbeat.sv
// top level of the client registry with heartbeat eviction and dispatch
// depends on crh_pkg, crh_if, crh_front and crh_back
//
// usage:
//   in_ch carries one command beat: kind, name_key, client_id, link.
//   out_ch carries result beats: status, out_id, out_link, job_number, last;
//   last marks the final beat of the results of one command.
//   cfg_ch writes the client limit; it is always ready and should be written
//   only while no command is in flight.
// sequencing:
//   a command beat enters a two-deep command queue, so in_ch keeps taking
//   beats while a result waits on out_ch. the back sequencer handles one
//   command at a time; a register result is valid the cycle after the back
//   takes the command. dispatch holds the back while the bit-serial remainder
//   unit forms the round-robin counter mod the entry count; a sweep removes
//   the evicted entries one by one, then sends one ping beat per remaining
//   entry, or a single none beat when no entry remains.
// reset:
//   rst_n (synchronous, active low) empties the table and the queue, clears
//   next id, round-robin and job counters, and sets the client limit to 20.
// stalls:
//   when out_ch.ready is low the result register holds its beat and the
//   back part waits; the queue then fills and in_ch.ready drops.
module client_registry_heartbeat #(
  parameter int TABLE_SIZE = crh_pkg::TABLE_SIZE_DEF,
  parameter int KEY_BITS   = crh_pkg::KEY_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  crh_in_if.sink     in_ch,
  crh_out_if.source  out_ch,
  crh_cfg_if.sink    cfg_ch
);

  logic          cmd_valid, cmd_pop;
  crh_pkg::cmd_t cmd;
  logic [5:0]    client_limit_r;

  // configuration register, write beat always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      client_limit_r <= crh_pkg::CLIENT_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      client_limit_r <= cfg_ch.client_limit;
    end
  end

  // front: take and classify commands
  crh_front #(.KEY_BITS(KEY_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // back: table, sweep and dispatch sequencer, result register
  crh_back #(.TABLE_SIZE(TABLE_SIZE), .KEY_BITS(KEY_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .client_limit (client_limit_r),
    .out_ch       (out_ch)
  );

endmodule

### design/crh_front.sv
// front part: accepts input beats, classifies kind, two-entry command queue
// depends on crh_pkg and crh_if
module crh_front #(
  parameter int KEY_BITS = crh_pkg::KEY_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  crh_in_if.sink        in_ch,
  output logic          cmd_valid,
  output crh_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  crh_pkg::cmd_t q_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    fill_r, fill_nxt;
  logic          push, known;
  crh_pkg::cmd_t new_cmd;
  logic [63:0]   key_mask;

  assign key_mask = (KEY_BITS >= 64) ? {64{1'b1}} : ((64'd1 << KEY_BITS) - 64'd1);

  always_comb begin
    known       = 1'b1;
    new_cmd.op  = crh_pkg::OP_REG;
    unique case (in_ch.kind)
      crh_pkg::KIND_REGISTER:   new_cmd.op = crh_pkg::OP_REG;
      crh_pkg::KIND_PONG:       new_cmd.op = crh_pkg::OP_PONG;
      crh_pkg::KIND_UNREGISTER: new_cmd.op = crh_pkg::OP_UNREG;
      crh_pkg::KIND_SWEEP:      new_cmd.op = crh_pkg::OP_SWEEP;
      crh_pkg::KIND_DISPATCH:   new_cmd.op = crh_pkg::OP_DISP;
      default:                  known = 1'b0;
    endcase
    new_cmd.key  = in_ch.name_key & key_mask;
    new_cmd.id   = in_ch.client_id;
    new_cmd.link = in_ch.link;
  end

  assign in_ch.ready = (fill_r != 2'd2);
  // undefined kinds are taken and dropped
  assign push      = in_ch.valid && in_ch.ready && known;
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

### design/crh_mod.sv
// iterative remainder unit, one dividend bit per cycle
// depends on nothing
module crh_mod #(
  parameter int NW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] rem
);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [4:0]    step_r, step_nxt;
  logic [31:0]   quo_r, quo_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] div_r, div_nxt;
  logic [NW:0]   trial;

  assign trial = {rem_r, quo_r[31]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      step_nxt = 5'd31;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[30:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = NW'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = NW'(trial);
      end
      step_nxt = step_r - 5'd1;
      if (step_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### design/crh_back.sv
// back part: client table, sequencer for sweep and dispatch, result register
// depends on crh_pkg, crh_if, crh_mod and the assertion macros
`include "client_registry_heartbeat_macros.svh"
module crh_back #(
  parameter int TABLE_SIZE = crh_pkg::TABLE_SIZE_DEF,
  parameter int KEY_BITS   = crh_pkg::KEY_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  crh_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic [5:0]    client_limit,
  crh_out_if.source     out_ch
);

  localparam int CAP = (TABLE_SIZE < crh_pkg::MAX_RESULTS) ? TABLE_SIZE : crh_pkg::MAX_RESULTS;
  localparam int IW  = $clog2(CAP);
  localparam int CW  = $clog2(CAP + 1);

  // table, a prefix of cnt_r entries kept in id order
  logic [15:0]         ent_id_r    [CAP];
  logic [KEY_BITS-1:0] ent_key_r   [CAP];
  logic                ent_link_r  [CAP];
  logic                ent_alive_r [CAP];

  logic [CW-1:0]   cnt_r;
  logic [15:0]     next_id_r;
  logic [31:0]     rr_r, job_r;
  logic [IW-1:0]   idx_r, idx_nxt;
  crh_pkg::state_t state_r, state_nxt;

  logic            out_vld_r;
  crh_pkg::status_t out_stat_r;
  logic [15:0]     out_id_r;
  logic            out_link_r, out_last_r;
  logic [31:0]     out_job_r;

  logic            out_free;
  logic [CAP-1:0]  key_hit, id_hit, dead, id_ge;
  logic            name_used, id_found, dead_found, full;
  logic [IW-1:0]   id_pos, dead_pos, ins_pos;
  logic            div_start, div_done;
  logic [CW-1:0]   div_rem;
  logic [IW-1:0]   rd_idx;

  // control decided this cycle
  logic            emit, do_ins, do_rem, set_alive, clr_alive, bump;
  logic [IW-1:0]   rem_pos, alive_pos;
  crh_pkg::status_t r_stat;
  logic [15:0]     r_id;
  logic            r_link, r_last;
  logic [31:0]     r_job;

  assign out_free = !out_vld_r || out_ch.ready;
  assign full = (7'(cnt_r) >= 7'(client_limit)) || (cnt_r >= CW'(CAP));

  // parallel lookups over the table
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      key_hit[i] = (CW'(i) < cnt_r) && (ent_key_r[i] == cmd.key[KEY_BITS-1:0]);
      id_hit[i]  = (CW'(i) < cnt_r) && (ent_id_r[i] == cmd.id);
      dead[i]    = (CW'(i) < cnt_r) && !ent_alive_r[i];
      id_ge[i]   = (CW'(i) >= cnt_r) || (ent_id_r[i] >= next_id_r);
    end
    name_used  = |key_hit;
    id_found   = |id_hit;
    dead_found = |dead;
    id_pos   = '0;
    dead_pos = '0;
    ins_pos  = '0;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (id_hit[i]) id_pos = IW'(i);
      if (dead[i]) dead_pos = IW'(i);
      if (id_ge[i]) ins_pos = IW'(i);
    end
  end

  crh_mod #(.NW(CW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rr_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign rd_idx = (state_r == crh_pkg::ST_DIV) ? div_rem[IW-1:0] : idx_r;

  // control outputs
  always_comb begin
    cmd_pop   = 1'b0;
    emit      = 1'b0;
    do_ins    = 1'b0;
    do_rem    = 1'b0;
    set_alive = 1'b0;
    clr_alive = 1'b0;
    bump      = 1'b0;
    div_start = 1'b0;
    rem_pos   = dead_pos;
    alive_pos = idx_r;
    r_stat    = crh_pkg::STAT_NONE;
    r_id      = '0;
    r_link    = 1'b0;
    r_job     = '0;
    r_last    = 1'b1;
    unique case (state_r)
      crh_pkg::ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            crh_pkg::OP_REG: begin
              emit   = 1'b1;
              r_link = cmd.link;
              if (full) begin
                r_stat = crh_pkg::STAT_FULL;
              end else if (name_used) begin
                r_stat = crh_pkg::STAT_NAME_USED;
              end else begin
                r_stat = crh_pkg::STAT_ACCEPTED;
                r_id   = next_id_r;
                do_ins = 1'b1;
              end
            end
            crh_pkg::OP_PONG: begin
              set_alive = id_found;
              alive_pos = id_pos;
            end
            crh_pkg::OP_UNREG: begin
              do_rem  = id_found;
              rem_pos = id_pos;
            end
            crh_pkg::OP_SWEEP: begin
            end
            crh_pkg::OP_DISP: begin
              if (cnt_r == '0) begin
                emit   = 1'b1;
                r_stat = crh_pkg::STAT_NO_CLIENT;
              end else begin
                div_start = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      crh_pkg::ST_DIV: begin
        if (div_done && out_free) begin
          emit   = 1'b1;
          bump   = 1'b1;
          r_stat = crh_pkg::STAT_DISPATCHED;
          r_id   = ent_id_r[rd_idx];
          r_link = ent_link_r[rd_idx];
          r_job  = job_r;
        end
      end
      crh_pkg::ST_COMPACT: begin
        if (dead_found) begin
          do_rem = 1'b1;
        end else if (cnt_r == '0 && out_free) begin
          emit   = 1'b1;
          r_stat = crh_pkg::STAT_NONE;
        end
      end
      crh_pkg::ST_PING: begin
        if (out_free) begin
          emit      = 1'b1;
          clr_alive = 1'b1;
          r_stat    = crh_pkg::STAT_PING;
          r_id      = ent_id_r[rd_idx];
          r_link    = ent_link_r[rd_idx];
          r_last    = (idx_r == IW'(cnt_r - CW'(1)));
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      crh_pkg::ST_IDLE: begin
        if (cmd_valid && out_free) begin
          if (cmd.op == crh_pkg::OP_SWEEP) begin
            state_nxt = crh_pkg::ST_COMPACT;
          end else if (cmd.op == crh_pkg::OP_DISP && cnt_r != '0) begin
            state_nxt = crh_pkg::ST_DIV;
          end
        end
      end
      crh_pkg::ST_DIV: begin
        if (div_done && out_free) state_nxt = crh_pkg::ST_IDLE;
      end
      crh_pkg::ST_COMPACT: begin
        idx_nxt = '0;
        if (!dead_found) begin
          if (cnt_r != '0) begin
            state_nxt = crh_pkg::ST_PING;
          end else if (out_free) begin
            state_nxt = crh_pkg::ST_IDLE;
          end
        end
      end
      crh_pkg::ST_PING: begin
        if (out_free) begin
          idx_nxt = idx_r + IW'(1);
          if (r_last) state_nxt = crh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = crh_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= crh_pkg::ST_IDLE;
      cnt_r     <= '0;
      next_id_r <= '0;
      rr_r      <= '0;
      job_r     <= '0;
      out_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (do_ins) begin
        cnt_r     <= cnt_r + CW'(1);
        next_id_r <= next_id_r + 16'd1;
      end else if (do_rem) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (bump) begin
        rr_r  <= rr_r + 32'd1;
        job_r <= job_r + 32'd1;
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_stat_r <= r_stat;
      out_id_r   <= r_id;
      out_link_r <= r_link;
      out_job_r  <= r_job;
      out_last_r <= r_last;
    end
  end

  // one row of entry cells; insert shifts up, remove shifts down
  for (genvar g = 0; g < CAP; g++) begin : g_ent
    logic [15:0]         prv_id, nxt_id;
    logic [KEY_BITS-1:0] prv_key, nxt_key;
    logic                prv_link, nxt_link, prv_alive, nxt_alive;
    if (g > 0) begin : g_prv
      assign prv_id    = ent_id_r[g-1];
      assign prv_key   = ent_key_r[g-1];
      assign prv_link  = ent_link_r[g-1];
      assign prv_alive = ent_alive_r[g-1];
    end else begin : g_prv0
      assign prv_id    = '0;
      assign prv_key   = '0;
      assign prv_link  = 1'b0;
      assign prv_alive = 1'b0;
    end
    if (g < CAP - 1) begin : g_nxt
      assign nxt_id    = ent_id_r[g+1];
      assign nxt_key   = ent_key_r[g+1];
      assign nxt_link  = ent_link_r[g+1];
      assign nxt_alive = ent_alive_r[g+1];
    end else begin : g_nxt0
      assign nxt_id    = '0;
      assign nxt_key   = '0;
      assign nxt_link  = 1'b0;
      assign nxt_alive = 1'b0;
    end

    always_ff @(posedge clk) begin
      if (do_ins) begin
        if (IW'(g) == ins_pos) begin
          ent_id_r[g]    <= next_id_r;
          ent_key_r[g]   <= cmd.key[KEY_BITS-1:0];
          ent_link_r[g]  <= cmd.link;
          ent_alive_r[g] <= 1'b1;
        end else if (IW'(g) > ins_pos) begin
          ent_id_r[g]    <= prv_id;
          ent_key_r[g]   <= prv_key;
          ent_link_r[g]  <= prv_link;
          ent_alive_r[g] <= prv_alive;
        end
      end else if (do_rem) begin
        if (IW'(g) >= rem_pos) begin
          ent_id_r[g]    <= nxt_id;
          ent_key_r[g]   <= nxt_key;
          ent_link_r[g]  <= nxt_link;
          ent_alive_r[g] <= nxt_alive;
        end
      end else if (IW'(g) == alive_pos) begin
        if (set_alive) ent_alive_r[g] <= 1'b1;
        else if (clr_alive) ent_alive_r[g] <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.status     = out_stat_r;
  assign out_ch.out_id     = out_id_r;
  assign out_ch.out_link   = out_link_r;
  assign out_ch.job_number = out_job_r;
  assign out_ch.last       = out_last_r;

  `CRH_ASSERT_ALWAYS(a_cnt_cap, cnt_r <= CW'(CAP), "table count beyond capacity")
  `CRH_ASSERT_IMPLY(a_ping_nonempty, state_r == crh_pkg::ST_PING, cnt_r != '0, "ping with empty table")
  `CRH_ASSERT_NEXT(a_ins_grows, do_ins, cnt_r == $past(cnt_r) + CW'(1), "insert did not grow table")

endmodule

### verif/testbench.sv
// self-checking testbench for the client registry with heartbeat eviction
// needs crh_pkg, crh_if and the client_registry_heartbeat design files
`timescale 1ns / 1ps

module testbench;

  localparam int CAPACITY    = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 64;   // covers the remainder walk of a dispatch

  // one client in the predicted table
  typedef struct {
    logic [15:0] id;
    logic [63:0] key;
    logic        link;
    logic        alive;
  } client_t;

  // one predicted result beat
  typedef struct {
    crh_pkg::status_t status;
    logic [15:0]      id;
    logic             link;
    logic [31:0]      job;
    logic             last;
  } beat_t;

  logic clk;
  logic rst_n;

  crh_in_if  in_bus ();
  crh_out_if out_bus ();
  crh_cfg_if cfg_bus ();

  client_registry_heartbeat DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // predicted state, kept in id order like the design's table
  client_t     roster[$];
  logic [15:0] next_client_id;
  logic [31:0] rr_count;
  logic [31:0] job_count;
  logic [5:0]  client_limit;

  beat_t       pending_beats[$];
  logic [63:0] recent_keys[$];   // pool of used keys, to hit the name-in-use case
  int          err_count;
  int          cycles;
  int          out_hold;
  bit          burst_mode;       // no idling on either side while set

  // clock, period 4 ns
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // global cycle guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // idle draw: mostly short gaps, now and then long ones
  function automatic int draw_idle();
    if (burst_mode) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 12);
    return $urandom_range(0, 2);
  endfunction

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    err_count++;
  endtask

  function automatic void push_beat(input crh_pkg::status_t st, input logic [15:0] id,
                                    input logic lnk, input logic [31:0] job,
                                    input logic lst);
    beat_t b;
    b.status = st;
    b.id     = id;
    b.link   = lnk;
    b.job    = job;
    b.last   = lst;
    pending_beats.push_back(b);
  endfunction

  // first table position holding this id, -1 when absent
  function automatic int find_client(input logic [15:0] id);
    foreach (roster[i])
      if (roster[i].id == id) return i;
    return -1;
  endfunction

  // table model: update state and queue the beats one command produces
  function automatic void predict_command(input logic [2:0] kind, input logic [63:0] key,
                                          input logic [15:0] id, input logic lnk);
    int      n;
    int      pos;
    client_t c;
    n = roster.size();
    case (kind)
      crh_pkg::KIND_REGISTER: begin
        if (n >= client_limit || n >= CAPACITY) begin
          push_beat(crh_pkg::STAT_FULL, 16'd0, lnk, 32'd0, 1'b1);
          return;
        end
        foreach (roster[i])
          if (roster[i].key == key) begin
            push_beat(crh_pkg::STAT_NAME_USED, 16'd0, lnk, 32'd0, 1'b1);
            return;
          end
        // new entry goes before the first id that is not smaller (matters after wrap)
        pos = 0;
        while (pos < n && roster[pos].id < next_client_id) pos++;
        c.id    = next_client_id;
        c.key   = key;
        c.link  = lnk;
        c.alive = 1'b1;
        roster.insert(pos, c);
        push_beat(crh_pkg::STAT_ACCEPTED, next_client_id, lnk, 32'd0, 1'b1);
        next_client_id = next_client_id + 16'd1;
      end
      crh_pkg::KIND_PONG: begin
        pos = find_client(id);
        if (pos >= 0) roster[pos].alive = 1'b1;
      end
      crh_pkg::KIND_UNREGISTER: begin
        pos = find_client(id);
        if (pos >= 0) roster.delete(pos);
      end
      crh_pkg::KIND_SWEEP: begin
        // evict every silent client, then ping the rest in id order
        pos = 0;
        while (pos < roster.size()) begin
          if (!roster[pos].alive) roster.delete(pos);
          else pos++;
        end
        if (roster.size() == 0) begin
          push_beat(crh_pkg::STAT_NONE, 16'd0, 1'b0, 32'd0, 1'b1);
          return;
        end
        foreach (roster[i]) begin
          roster[i].alive = 1'b0;
          push_beat(crh_pkg::STAT_PING, roster[i].id, roster[i].link, 32'd0,
                    (i == roster.size() - 1));
        end
      end
      crh_pkg::KIND_DISPATCH: begin
        if (n == 0) begin
          push_beat(crh_pkg::STAT_NO_CLIENT, 16'd0, 1'b0, 32'd0, 1'b1);
          return;
        end
        pos = rr_count % n;
        push_beat(crh_pkg::STAT_DISPATCHED, roster[pos].id, roster[pos].link, job_count,
                  1'b1);
        rr_count  = rr_count + 32'd1;
        job_count = job_count + 32'd1;
      end
      default: ;  // undefined kinds are dropped
    endcase
  endfunction

  // result side: random backpressure and field-by-field check of every beat
  always @(posedge clk) begin
    logic  nxt_ready;
    beat_t exp_beat;
    nxt_ready = 1'b1;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_beats.size() == 0) begin
        report($sformatf("unexpected beat status %0d id %0d", out_bus.status, out_bus.out_id));
      end else begin
        exp_beat = pending_beats.pop_front();
        if (out_bus.status !== exp_beat.status)
          report($sformatf("status %0d, want %0d", out_bus.status, exp_beat.status));
        if (out_bus.out_id !== exp_beat.id)
          report($sformatf("out_id %0d, want %0d", out_bus.out_id, exp_beat.id));
        if (out_bus.out_link !== exp_beat.link)
          report($sformatf("out_link %0b, want %0b", out_bus.out_link, exp_beat.link));
        if (out_bus.job_number !== exp_beat.job)
          report($sformatf("job_number %0d, want %0d", out_bus.job_number, exp_beat.job));
        if (out_bus.last !== exp_beat.last)
          report($sformatf("last %0b, want %0b", out_bus.last, exp_beat.last));
      end
      out_hold = draw_idle();
    end
    if (out_hold > 0) begin
      out_hold--;
      nxt_ready = 1'b0;
    end
    out_bus.ready <= nxt_ready;
  end

  // send one command beat; valid stays high across back-to-back beats
  task automatic send_command(input logic [2:0] kind, input logic [63:0] key,
                              input logic [15:0] id, input logic lnk);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.kind      <= kind;
    in_bus.name_key  <= key;
    in_bus.client_id <= id;
    in_bus.link      <= lnk;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predict_command(kind, key, id, lnk);
  endtask

  // wait for every expected beat, then let a silent command finish
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending_beats.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write the client limit; only called with the block idle
  task automatic write_client_limit(input logic [5:0] value);
    drain();
    cfg_bus.valid        <= 1'b1;
    cfg_bus.client_limit <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    client_limit = value;
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // register with either a fresh or a reused key
  task automatic register_client(input bit reuse);
    logic [63:0] key;
    if (reuse && recent_keys.size() > 0)
      key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    else
      key = rand_key();
    recent_keys.push_back(key);
    if (recent_keys.size() > 16) void'(recent_keys.pop_front());
    send_command(crh_pkg::KIND_REGISTER, key, 16'($urandom()), 1'($urandom()));
  endtask

  // id of a present client most of the time, otherwise any id
  function automatic logic [15:0] pick_id();
    if (roster.size() > 0 && $urandom_range(0, 4) != 0)
      return roster[$urandom_range(0, roster.size() - 1)].id;
    return 16'($urandom());
  endfunction

  // field extremes, every kind and the empty-table cases
  task automatic test_directed();
    send_command(crh_pkg::KIND_DISPATCH, '0, '0, 1'b0);          // empty table dispatch
    send_command(crh_pkg::KIND_SWEEP, '0, '0, 1'b0);             // empty table sweep
    send_command(crh_pkg::KIND_PONG, '0, 16'hFFFF, 1'b0);        // unknown id ignored
    send_command(crh_pkg::KIND_UNREGISTER, '0, 16'h0000, 1'b1);  // unknown id ignored
    send_command(crh_pkg::KIND_REGISTER, 64'h0, 16'hFFFF, 1'b0);
    send_command(crh_pkg::KIND_REGISTER, '1, 16'h0000, 1'b1);
    send_command(crh_pkg::KIND_REGISTER, 64'h0, 16'h1234, 1'b1); // name in use
    send_command(crh_pkg::KIND_REGISTER, 64'h5555_AAAA_0F0F_F0F0, '1, 1'b0);
    send_command(crh_pkg::KIND_DISPATCH, '1, '1, 1'b1);
    send_command(crh_pkg::KIND_DISPATCH, '0, '0, 1'b0);
    send_command(crh_pkg::KIND_DISPATCH, '0, '0, 1'b0);
    send_command(crh_pkg::KIND_DISPATCH, '0, '0, 1'b0);          // wraps around the table
    send_command(crh_pkg::KIND_PONG, '0, 16'd1, 1'b0);
    send_command(3'd5, '1, '1, 1'b1);                            // undefined kinds
    send_command(3'd6, '0, '0, 1'b0);
    send_command(3'd7, '1, 16'd0, 1'b1);
    send_command(crh_pkg::KIND_SWEEP, '0, '0, 1'b0);             // all alive after register
    send_command(crh_pkg::KIND_PONG, '0, 16'd2, 1'b0);
    send_command(crh_pkg::KIND_SWEEP, '0, '0, 1'b0);             // evicts 0 and 1
    send_command(crh_pkg::KIND_UNREGISTER, '0, 16'd2, 1'b0);
    send_command(crh_pkg::KIND_DISPATCH, '0, '0, 1'b0);          // empty again
    send_command(crh_pkg::KIND_SWEEP, '0, '0, 1'b0);
  endtask

  // limits on the table size from the client limit and the hard capacity
  task automatic test_capacity();
    write_client_limit(6'd0);
    register_client(0);                                           // refused
    write_client_limit(6'd1);
    register_client(0);
    register_client(0);                                           // full at one
    write_client_limit(6'd63);
    while (roster.size() < CAPACITY) register_client(0);
    register_client(0);                                           // full at capacity
    send_command(crh_pkg::KIND_DISPATCH, '0, '0, 1'b0);
    send_command(crh_pkg::KIND_SWEEP, '0, '0, 1'b0);             // 32 pings
    write_client_limit(6'd32);
    send_command(crh_pkg::KIND_SWEEP, '0, '0, 1'b0);             // evicts everything
    write_client_limit(6'd20);
  endtask

  // random traffic: registers, pongs, unregisters, sweeps, dispatches, some undefined kinds
  task automatic run_random(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      register_client($urandom_range(0, 3) == 0);
      else if (pick < 52) send_command(crh_pkg::KIND_PONG, rand_key(), pick_id(),
                                       1'($urandom()));
      else if (pick < 60) send_command(crh_pkg::KIND_UNREGISTER, rand_key(), pick_id(),
                                       1'($urandom()));
      else if (pick < 70) send_command(crh_pkg::KIND_SWEEP, rand_key(), 16'($urandom()),
                                       1'($urandom()));
      else if (pick < 96) send_command(crh_pkg::KIND_DISPATCH, rand_key(), 16'($urandom()),
                                       1'($urandom()));
      else                send_command(3'($urandom_range(5, 7)), rand_key(), 16'($urandom()),
                                       1'($urandom()));
    end
  endtask

  task automatic test_random();
    run_random(75);
    drain();                                             // sender holds off until all results are in
    burst_mode = 1'b1;
    run_random(30);
    burst_mode = 1'b0;
    write_client_limit(6'($urandom_range(1, 12)));
    run_random(65);
    write_client_limit(6'd63);
    run_random(65);
    write_client_limit(6'($urandom_range(2, 40)));
    run_random(65);
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_bus.valid         <= 1'b0;
    in_bus.kind          <= '0;
    in_bus.name_key      <= '0;
    in_bus.client_id     <= '0;
    in_bus.link          <= 1'b0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.client_limit <= '0;
    cycles         = 0;
    err_count      = 0;
    out_hold       = 0;
    burst_mode     = 1'b0;
    next_client_id = '0;
    rr_count       = '0;
    job_count      = '0;
    client_limit   = crh_pkg::CLIENT_LIMIT_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_capacity();
    test_random();

    drain();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/crh_pkg.sv
design/crh_if.sv
design/crh_front.sv
design/crh_mod.sv
design/crh_back.sv
design/client_registry_heartbeat.sv
verif/testbench.sv
